// ===== rtl/sstws_pkg.sv =====
// Shared constants and the digit-to-segment table for the two-wire sender.
// No dependencies; imported by every module of the block.
`default_nettype none

package sstws_pkg;

    localparam int DIGITS_DEF = 4;
    localparam int FRAME_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DATA_CMD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_CMD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISP_CTL = 2'd2;

    localparam logic [7:0] DATA_CMD_RST = 8'h40;
    localparam logic [7:0] ADDR_CMD_RST = 8'hc0;
    localparam logic [7:0] DISP_CTL_RST = 8'h8c;

    localparam logic [7:0] ASCII_ZERO = 8'h30;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    function automatic logic [7:0] seg_code(input logic [3:0] idx);
        logic [7:0] code;
        case (idx)
            4'd0: code = 8'h3f;
            4'd1: code = 8'h06;
            4'd2: code = 8'h5b;
            4'd3: code = 8'h4f;
            4'd4: code = 8'h66;
            4'd5: code = 8'h6d;
            4'd6: code = 8'h7d;
            4'd7: code = 8'h07;
            4'd8: code = 8'h7f;
            4'd9: code = 8'h6f;
            default: code = 8'h3f;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/seven_segment_two_wire_sender.sv =====
// Two-wire seven-segment display sender: load requests arm a frame sequence,
// tick requests advance the clock/data waveform by one phase each.
// Uses sstws_pkg and sstws_digit_map.
// An accepted request's result enters the output register in the cycle after.
// Throughput: one request per cycle while m_tready is high or the output is empty.
// Reset (aresetn low, synchronous): idle, both lines high, registers at defaults.
`default_nettype none

module seven_segment_two_wire_sender
    import sstws_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // digit_zero, digit_one, digit_two, digit_three, digit_count, dio_sample
    input  wire logic [47:0]           s_tdata,
    // command
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // clock_line, data_line, busy_res
    output logic [7:0]                 m_tdata,
    output logic                       m_tlast
);

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_START0   = 4'd1,
        PH_START1   = 4'd2,
        PH_START2   = 4'd3,
        PH_BIT_LOW  = 4'd4,
        PH_BIT_SET  = 4'd5,
        PH_BIT_HIGH = 4'd6,
        PH_ACK_REL  = 4'd7,
        PH_ACK_WAIT = 4'd8,
        PH_ACK_LOW  = 4'd9,
        PH_STOP0    = 4'd10,
        PH_STOP1    = 4'd11,
        PH_STOP2    = 4'd12,
        PH_STOP3    = 4'd13
    } phase_t;

    typedef logic [DIGITS-1:0][7:0] seg_buf_t;

    localparam logic [FRAME_W-1:0] LAST_SEG_SLOT = FRAME_W'(DIGITS + 1);
    localparam logic [FRAME_W-1:0] CTL_SLOT      = FRAME_W'(DIGITS + 2);

    logic [7:0]         data_cmd_reg, addr_cmd_reg, disp_ctl_reg;
    seg_buf_t           seg_buf_reg, seg_buf_next;
    logic [7:0]         shift_reg, shift_next;
    logic [2:0]         bit_pos_reg, bit_pos_next;
    phase_t             phase_reg, phase_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic               clk_lvl_reg, clk_lvl_next;
    logic               dat_lvl_reg, dat_lvl_next;
    logic               active_reg, active_next;
    logic               done_next;
    logic               m_tvalid_reg;
    logic [7:0]         m_tdata_reg, m_tdata_next;
    logic               m_tlast_reg;

    logic               s_accept;
    seg_buf_t           load_codes;
    logic [7:0]         slot_cur, slot_inc;
    logic               released;

    sstws_digit_map #(
        .DIGITS(DIGITS)
    ) u_digit_map (
        .chars      ({s_tdata[31:24], s_tdata[23:16], s_tdata[15:8], s_tdata[7:0]}),
        .char_count (s_tdata[39:32]),
        .codes      (load_codes)
    );

    function automatic logic [7:0] slot_byte(
        input logic [FRAME_W-1:0] fp,
        input seg_buf_t           sbuf,
        input logic [7:0]         dcmd,
        input logic [7:0]         acmd,
        input logic [7:0]         dctl
    );
        logic [7:0] b;
        b = dctl;
        if (fp == FRAME_W'(0)) begin
            b = dcmd;
        end else if (fp == FRAME_W'(1)) begin
            b = acmd;
        end else begin
            for (int i = 0; i < DIGITS; i++) begin
                if (fp == FRAME_W'(i + 2)) begin
                    b = sbuf[i];
                end
            end
        end
        return b;
    endfunction

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign slot_cur = slot_byte(frame_reg, seg_buf_reg, data_cmd_reg, addr_cmd_reg,
                                disp_ctl_reg);
    assign slot_inc = slot_byte(frame_reg + FRAME_W'(1), seg_buf_reg, data_cmd_reg,
                                addr_cmd_reg, disp_ctl_reg);

    always_comb begin
        seg_buf_next = seg_buf_reg;
        shift_next   = shift_reg;
        bit_pos_next = bit_pos_reg;
        phase_next   = phase_reg;
        frame_next   = frame_reg;
        clk_lvl_next = clk_lvl_reg;
        dat_lvl_next = dat_lvl_reg;
        active_next  = active_reg;
        done_next    = 1'b0;
        if (s_accept) begin
            if (s_tuser == CMD_LOAD) begin
                if (!active_reg) begin
                    seg_buf_next = load_codes;
                    active_next  = 1'b1;
                    frame_next   = '0;
                    bit_pos_next = '0;
                    phase_next   = PH_START0;
                end
            end else if (active_reg) begin
                case (phase_reg)
                    PH_START0: begin
                        clk_lvl_next = 1'b1;
                        phase_next   = PH_START1;
                    end
                    PH_START1: begin
                        dat_lvl_next = 1'b1;
                        phase_next   = PH_START2;
                    end
                    PH_START2: begin
                        dat_lvl_next = 1'b0;
                        shift_next   = slot_cur;
                        bit_pos_next = '0;
                        phase_next   = PH_BIT_LOW;
                    end
                    PH_BIT_LOW: begin
                        clk_lvl_next = 1'b0;
                        phase_next   = PH_BIT_SET;
                    end
                    PH_BIT_SET: begin
                        dat_lvl_next = shift_reg[0];
                        shift_next   = {1'b0, shift_reg[7:1]};
                        phase_next   = PH_BIT_HIGH;
                    end
                    PH_BIT_HIGH: begin
                        clk_lvl_next = 1'b1;
                        if (bit_pos_reg == 3'd7) begin
                            bit_pos_next = '0;
                            phase_next   = PH_ACK_REL;
                        end else begin
                            bit_pos_next = bit_pos_reg + 3'd1;
                            phase_next   = PH_BIT_LOW;
                        end
                    end
                    PH_ACK_REL: begin
                        clk_lvl_next = 1'b0;
                        phase_next   = PH_ACK_WAIT;
                    end
                    PH_ACK_WAIT: begin
                        if (!s_tdata[40]) begin
                            clk_lvl_next = 1'b1;
                            phase_next   = PH_ACK_LOW;
                        end
                    end
                    PH_ACK_LOW: begin
                        clk_lvl_next = 1'b0;
                        if (frame_reg == FRAME_W'(0) || frame_reg == LAST_SEG_SLOT ||
                            frame_reg == CTL_SLOT) begin
                            phase_next = PH_STOP0;
                        end else begin
                            frame_next   = frame_reg + FRAME_W'(1);
                            shift_next   = slot_inc;
                            bit_pos_next = '0;
                            phase_next   = PH_BIT_LOW;
                        end
                    end
                    PH_STOP0: begin
                        clk_lvl_next = 1'b0;
                        phase_next   = PH_STOP1;
                    end
                    PH_STOP1: begin
                        dat_lvl_next = 1'b0;
                        phase_next   = PH_STOP2;
                    end
                    PH_STOP2: begin
                        clk_lvl_next = 1'b1;
                        phase_next   = PH_STOP3;
                    end
                    PH_STOP3: begin
                        dat_lvl_next = 1'b1;
                        if (frame_reg >= CTL_SLOT) begin
                            done_next   = 1'b1;
                            active_next = 1'b0;
                            frame_next  = '0;
                            phase_next  = PH_IDLE;
                        end else begin
                            frame_next = frame_reg + FRAME_W'(1);
                            phase_next = PH_START0;
                        end
                    end
                    default: begin
                        active_next  = 1'b0;
                        frame_next   = '0;
                        bit_pos_next = '0;
                        phase_next   = PH_IDLE;
                    end
                endcase
            end
        end
        released     = active_next && (phase_next == PH_ACK_WAIT || phase_next == PH_ACK_LOW);
        m_tdata_next = {5'b0, active_next, released | dat_lvl_next, clk_lvl_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_cmd_reg <= DATA_CMD_RST;
            addr_cmd_reg <= ADDR_CMD_RST;
            disp_ctl_reg <= DISP_CTL_RST;
            seg_buf_reg  <= '0;
            shift_reg    <= '0;
            bit_pos_reg  <= '0;
            phase_reg    <= PH_IDLE;
            frame_reg    <= '0;
            clk_lvl_reg  <= 1'b1;
            dat_lvl_reg  <= 1'b1;
            active_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_DATA_CMD: data_cmd_reg <= cfg_wdata;
                    CFG_ADDR_CMD: addr_cmd_reg <= cfg_wdata;
                    CFG_DISP_CTL: disp_ctl_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            seg_buf_reg <= seg_buf_next;
            shift_reg   <= shift_next;
            bit_pos_reg <= bit_pos_next;
            phase_reg   <= phase_next;
            frame_reg   <= frame_next;
            clk_lvl_reg <= clk_lvl_next;
            dat_lvl_reg <= dat_lvl_next;
            active_reg  <= active_next;
            if (s_accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= m_tdata_next;
            m_tlast_reg <= done_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_active_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg == (phase_reg != PH_IDLE))
        else $error("sequencer active flag disagrees with phase");

    a_frame_range: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_reg <= CTL_SLOT)
        else $error("frame position beyond control byte slot");

    a_load_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == CMD_LOAD && !active_reg)
        |=> (active_reg && phase_reg == PH_START0 && frame_reg == '0))
        else $error("idle load request did not arm the sequence");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> !m_tdata[2])
        else $error("sequence end reported while still busy");

endmodule

`default_nettype wire

// ===== rtl/sstws_digit_map.sv =====
// Maps the ASCII characters of a load request to seven-segment codes.
// Depends on sstws_pkg for the segment table.
`default_nettype none

module sstws_digit_map
    import sstws_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEF
) (
    input  wire logic [3:0][7:0]        chars,
    input  wire logic [7:0]             char_count,
    output logic      [DIGITS-1:0][7:0] codes
);

    always_comb begin
        logic [7:0] diff;
        for (int i = 0; i < DIGITS; i++) begin
            codes[i] = seg_code(4'd0);
            if (i < 4) begin
                diff = chars[i % 4] - ASCII_ZERO;
                if (char_count > 8'(i) && diff <= 8'd9) begin
                    codes[i] = seg_code(diff[3:0]);
                end
            end
        end
    end

endmodule

`default_nettype wire
